// ----- design/hchc_pkg.sv -----
// Shared types, codes and clamp helpers for the HVAC call hysteresis controller.
// No dependencies; every other design file takes names from here by scope.
`default_nettype none
package hchc_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_MODE         = 3'd0;
  localparam logic [2:0] REG_HYSTERESIS   = 3'd1;
  localparam logic [2:0] REG_MIN_GAP      = 3'd2;
  localparam logic [2:0] REG_MIN_SETPOINT = 3'd3;
  localparam logic [2:0] REG_MAX_SETPOINT = 3'd4;

  // Reset values of the configuration registers
  localparam logic [1:0] MODE_RST         = 2'd0;
  localparam logic [6:0] HYSTERESIS_RST   = 7'd10;
  localparam logic [7:0] MIN_GAP_RST      = 8'd30;
  localparam logic [9:0] MIN_SETPOINT_RST = 10'd450;
  localparam logic [9:0] MAX_SETPOINT_RST = 10'd900;

  // Setpoint reset values in tenths of a degree
  localparam logic [9:0] HEAT_POINT_RST = 10'd680;
  localparam logic [9:0] COOL_POINT_RST = 10'd760;
  localparam logic signed [12:0] SETPOINT_CEIL = 13'sd1023;

  // Input kind codes
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_HEAT   = 2'd1;
  localparam logic [1:0] KIND_COOL   = 2'd2;

  // Call state codes
  localparam logic [1:0] CALL_IDLE = 2'd0;
  localparam logic [1:0] CALL_HEAT = 2'd1;
  localparam logic [1:0] CALL_COOL = 2'd2;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_ADJ_HEAT,
    OP_ADJ_COOL,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e                op;
    logic signed [11:0] temp;
    logic signed [9:0]  delta;
  } item_t;

  // Low bound tested first: with crossed bounds, x below lo gives lo, else hi
  function automatic logic signed [12:0] clamp_low_first(
    input logic signed [12:0] x,
    input logic signed [12:0] lo,
    input logic signed [12:0] hi
  );
    logic signed [12:0] r;
    if (x < lo) begin
      r = lo;
    end else if (x > hi) begin
      r = hi;
    end else begin
      r = x;
    end
    return r;
  endfunction

  // Saturate to the 10-bit setpoint range
  function automatic logic [9:0] sat_setpoint(input logic signed [12:0] x);
    logic [9:0] r;
    if (x < 13'sd0) begin
      r = 10'd0;
    end else if (x > SETPOINT_CEIL) begin
      r = SETPOINT_CEIL[9:0];
    end else begin
      r = x[9:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/hchc_front.sv -----
// Front end: takes input transactions and classifies them into queue items.
// Depends on hchc_pkg.
`default_nettype none
module hchc_front (
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         kind_i,
  input  wire logic signed [11:0] temp_i,
  input  wire logic signed [9:0]  delta_i,
  output logic                    push_o,
  input  wire logic               q_ready_i,
  output hchc_pkg::item_t         item_o
);

  hchc_pkg::op_e op;

  always_comb begin
    case (kind_i)
      hchc_pkg::KIND_SAMPLE: op = hchc_pkg::OP_SAMPLE;
      hchc_pkg::KIND_HEAT:   op = hchc_pkg::OP_ADJ_HEAT;
      hchc_pkg::KIND_COOL:   op = hchc_pkg::OP_ADJ_COOL;
      default:               op = hchc_pkg::OP_NONE;
    endcase
  end

  assign item_o.op    = op;
  assign item_o.temp  = temp_i;
  assign item_o.delta = delta_i;

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && q_ready_i;

endmodule
`default_nettype wire

// ----- design/hchc_queue.sv -----
// Short FIFO of classified items between the front end and the back end.
// Depends on hchc_pkg.
`default_nettype none
module hchc_queue #(
  parameter int Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire hchc_pkg::item_t  item_i,
  output logic                  ready_o,
  output logic                  valid_o,
  input  wire logic             pop_i,
  output hchc_pkg::item_t       item_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  hchc_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign ready_o = (cnt_q != FullCnt);
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt) else $error("queue count above depth");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("queue count missed a push");
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == FullCnt) |=> $stable(wr_ptr_q))
    else $error("write pointer moved while full");
`endif

endmodule
`default_nettype wire

// ----- design/hchc_back.sv -----
// Back end: config registers, setpoint clamp, call state machine, output register.
// Depends on hchc_pkg.
`default_nettype none
module hchc_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_idx_i,
  input  wire logic [9:0]       cfg_wdata_i,
  input  wire logic             q_valid_i,
  input  wire hchc_pkg::item_t  item_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [1:0]            call_o,
  output logic [9:0]            heat_setpoint_o,
  output logic [9:0]            cool_setpoint_o
);

  logic [1:0] mode_q;
  logic [6:0] hyst_q;
  logic [7:0] gap_q;
  logic [9:0] min_sp_q;
  logic [9:0] max_sp_q;

  logic [1:0] call_q, call_d;
  logic [9:0] heat_q, heat_d;
  logic [9:0] cool_q, cool_d;

  logic       out_valid_q;
  logic [1:0] out_call_q;
  logic [9:0] out_heat_q;
  logic [9:0] out_cool_q;

  logic               pop;
  logic               heat_ok, cool_ok;
  logic               heat_rel, cool_rel, heat_start, cool_start;
  logic [1:0]         call_rel;
  logic signed [12:0] heat_s, cool_s, gap_s, hyst_s, temp_s, delta_s;
  logic signed [12:0] heat_sum, cool_sum;

  // Take a queue item whenever the output register is free or being drained
  assign pop   = q_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= hchc_pkg::MODE_RST;
      hyst_q   <= hchc_pkg::HYSTERESIS_RST;
      gap_q    <= hchc_pkg::MIN_GAP_RST;
      min_sp_q <= hchc_pkg::MIN_SETPOINT_RST;
      max_sp_q <= hchc_pkg::MAX_SETPOINT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hchc_pkg::REG_MODE:         mode_q   <= cfg_wdata_i[1:0];
        hchc_pkg::REG_HYSTERESIS:   hyst_q   <= cfg_wdata_i[6:0];
        hchc_pkg::REG_MIN_GAP:      gap_q    <= cfg_wdata_i[7:0];
        hchc_pkg::REG_MIN_SETPOINT: min_sp_q <= cfg_wdata_i;
        hchc_pkg::REG_MAX_SETPOINT: max_sp_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign heat_s  = $signed({3'b000, heat_q});
  assign cool_s  = $signed({3'b000, cool_q});
  assign gap_s   = $signed({5'b00000, gap_q});
  assign hyst_s  = $signed({6'b000000, hyst_q});
  assign temp_s  = $signed({item_i.temp[11], item_i.temp});
  assign delta_s = $signed({{3{item_i.delta[9]}}, item_i.delta});

  assign heat_sum = heat_s + delta_s;
  assign cool_sum = cool_s + delta_s;

  assign heat_ok = mode_q[0];
  assign cool_ok = mode_q[1];

  // Release first, then a new call from idle needs the hysteresis margin
  assign heat_rel = (call_q == hchc_pkg::CALL_HEAT) && (!heat_ok || temp_s >= heat_s);
  assign cool_rel = (call_q == hchc_pkg::CALL_COOL) && (!cool_ok || temp_s <= cool_s);
  assign call_rel = (heat_rel || cool_rel) ? hchc_pkg::CALL_IDLE : call_q;
  assign heat_start = heat_ok && (temp_s <= heat_s - hyst_s);
  assign cool_start = cool_ok && (temp_s >= cool_s + hyst_s);

  always_comb begin
    call_d = call_q;
    heat_d = heat_q;
    cool_d = cool_q;
    case (item_i.op)
      hchc_pkg::OP_SAMPLE: begin
        call_d = call_rel;
        if (call_rel == hchc_pkg::CALL_IDLE) begin
          if (heat_start) begin
            call_d = hchc_pkg::CALL_HEAT;
          end else if (cool_start) begin
            call_d = hchc_pkg::CALL_COOL;
          end
        end
      end
      hchc_pkg::OP_ADJ_HEAT: begin
        heat_d = hchc_pkg::sat_setpoint(hchc_pkg::clamp_low_first(
          heat_sum, $signed({3'b000, min_sp_q}), cool_s - gap_s));
      end
      hchc_pkg::OP_ADJ_COOL: begin
        cool_d = hchc_pkg::sat_setpoint(hchc_pkg::clamp_low_first(
          cool_sum, heat_s + gap_s, $signed({3'b000, max_sp_q})));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      call_q      <= hchc_pkg::CALL_IDLE;
      heat_q      <= hchc_pkg::HEAT_POINT_RST;
      cool_q      <= hchc_pkg::COOL_POINT_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        call_q      <= call_d;
        heat_q      <= heat_d;
        cool_q      <= cool_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_call_q <= call_d;
      out_heat_q <= heat_d;
      out_cool_q <= cool_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign call_o          = out_call_q;
  assign heat_setpoint_o = out_heat_q;
  assign cool_setpoint_o = out_cool_q;

`ifndef SYNTHESIS
  a_no_pop_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !pop) else $error("pop while output stalled");
  a_pop_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (out_valid_q && out_call_q == call_q && out_heat_q == heat_q
             && out_cool_q == cool_q)) else $error("output does not match state");
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop |=> ($stable(call_q) && $stable(heat_q) && $stable(cool_q)))
    else $error("state changed without an item");
`endif

endmodule
`default_nettype wire

// ----- design/hvac_call_hysteresis_controller_top.sv -----
// Top level of the HVAC call hysteresis controller: front end, queue, back end.
// Depends on hchc_pkg, hchc_front, hchc_queue and hchc_back.
//
// Usage:
//   Input stream s_axis: tuser carries the item kind (sample, heat adjust, cool adjust),
//   tdata the indoor temperature and setpoint delta. Output stream m_axis returns one
//   transaction per input transaction: call state and both setpoints after that item.
//   Configuration: write cfg_wdata_i to register cfg_idx_i when cfg_we_i is high
//   (0 mode, 1 hysteresis, 2 min gap, 3 min setpoint, 4 max setpoint); write only
//   while no transaction is in flight.
// Timing:
//   A transaction accepted into the queue is executed by the back end straight from the
//   queue head and lands in the output register, which drives m_axis_tvalid; the
//   queue register and the output register lie between the input and the output
//   handshake. One transaction per cycle is sustained while m_axis_tready is high;
//   the clamp and compare path in the back end is combinational.
// Reset:
//   Call goes idle, setpoints return to 68.0 F / 76.0 F, registers to defaults.
// Stall:
//   When m_axis_tready is low the output register holds; the queue takes up to
//   QueueDepth more transactions before s_axis_tready drops.
`default_nettype none
module hvac_call_hysteresis_controller_top #(
  parameter int QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [9:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // indoor_temp[11:0], delta[21:12], zero pad
  input  wire logic [1:0]  s_axis_tuser,   // kind[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata    // call[1:0], heat_setpoint[11:2],
                                           // cool_setpoint[21:12], zero pad
);

  hchc_pkg::item_t front_item, q_item;
  logic            push, q_ready, q_valid, pop;
  logic [1:0]      call;
  logic [9:0]      heat_sp, cool_sp;

  hchc_front u_front (
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .kind_i     (s_axis_tuser),
    .temp_i     ($signed(s_axis_tdata[11:0])),
    .delta_i    ($signed(s_axis_tdata[21:12])),
    .push_o     (push),
    .q_ready_i  (q_ready),
    .item_o     (front_item)
  );

  hchc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .pop_i   (pop),
    .item_o  (q_item)
  );

  hchc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .q_valid_i       (q_valid),
    .item_i          (q_item),
    .pop_o           (pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .call_o          (call),
    .heat_setpoint_o (heat_sp),
    .cool_setpoint_o (cool_sp)
  );

  assign m_axis_tdata = {2'b00, cool_sp, heat_sp, call};

endmodule
`default_nettype wire
